@@ rtl/cdsu_pkg.sv @@
`default_nettype none

package cdsu_pkg;

   // descriptor type codes
   localparam logic [7:0] DESC_TYPE_INTF = 8'd4;
   localparam logic [7:0] DESC_TYPE_ENDP = 8'd5;

   // byte offsets inside one descriptor
   localparam logic [7:0] OFS_TYPE     = 8'd1;
   localparam logic [7:0] OFS_NUM      = 8'd2;
   localparam logic [7:0] OFS_ATTR     = 8'd3;
   localparam logic [7:0] OFS_PKT_LO   = 8'd4;
   localparam logic [7:0] OFS_PKT_HI   = 8'd5;
   localparam logic [7:0] OFS_INTERVAL = 8'd6;

   // shortest legal descriptor length
   localparam logic [7:0] MIN_DESC_LEN = 8'd2;

   // transfer type code for bulk
   localparam logic [1:0] XFER_BULK = 2'd2;

   // result kinds
   localparam logic KIND_ENDP    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // result fields, endp_num in the lowest bits
   typedef struct packed {
      logic       malformed;
      logic [4:0] endp_count;
      logic [8:0] intf_count;
      logic       int_bank;
      logic [7:0] poll_interval;
      logic [7:0] max_pkt_units;
      logic [15:0] max_packet;
      logic [1:0] xfer_type;
      logic       is_tx;
      logic [3:0] endp_num;
   } fields_type;

   typedef struct packed {
      logic       kind;
      logic       last;
      fields_type fields;
   } result_type;

   // what the scanner hands to the result queue for one transfer
   typedef struct packed {
      logic       rec_valid;
      logic       sum_valid;
      result_type rec;
      result_type sum;
   } scan_out_type;

endpackage

`default_nettype wire

@@ rtl/cdsu_parse.sv @@
`default_nettype none

module cdsu_parse
   import cdsu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire logic [7:0]   data_byte,
   input  wire logic         last_byte,
   input  wire logic         host_role,
   output scan_out_type      scan_out
);

   logic [7:0]  off_ff, off_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  attr_ff, attr_in;
   logic [15:0] psize_ff, psize_in;
   logic [7:0]  max_intf_ff, max_intf_in;
   logic [3:0]  max_endp_ff, max_endp_in;
   logic        bad_ff, bad_in;

   logic [8:0]  off_plus;
   logic [7:0]  n_max_intf;
   logic [3:0]  n_max_endp;
   logic        n_bad;

   // walk the descriptor chain and build the results for this byte
   always_comb begin
      off_in      = off_ff;
      len_in      = len_ff;
      type_in     = type_ff;
      addr_in     = addr_ff;
      attr_in     = attr_ff;
      psize_in    = psize_ff;
      n_max_intf  = max_intf_ff;
      n_max_endp  = max_endp_ff;
      n_bad       = bad_ff;
      off_plus    = {1'b0, off_ff} + 9'd1;
      scan_out    = '0;

      if (!bad_ff) begin
         if (off_ff == '0) begin
            len_in = data_byte;
            if (data_byte < MIN_DESC_LEN) begin
               n_bad = 1'b1;
            end else begin
               off_in = OFS_TYPE;
            end
         end else begin
            if (off_ff == OFS_TYPE) begin
               type_in = data_byte;
            end else if (type_ff == DESC_TYPE_INTF && off_ff == OFS_NUM) begin
               if (data_byte > max_intf_ff) begin
                  n_max_intf = data_byte;
               end
            end else if (type_ff == DESC_TYPE_ENDP) begin
               case (off_ff)
                  OFS_NUM: begin
                     addr_in = data_byte;
                     if (data_byte[3:0] > max_endp_ff) begin
                        n_max_endp = data_byte[3:0];
                     end
                  end
                  OFS_ATTR: begin
                     attr_in = data_byte;
                  end
                  OFS_PKT_LO: begin
                     psize_in = {8'h00, data_byte};
                  end
                  OFS_PKT_HI: begin
                     psize_in = {data_byte, psize_ff[7:0]};
                  end
                  OFS_INTERVAL: begin
                     scan_out.rec_valid                   = 1'b1;
                     scan_out.rec.kind                    = KIND_ENDP;
                     scan_out.rec.last                    = !last_byte;
                     scan_out.rec.fields.endp_num         = addr_ff[3:0];
                     scan_out.rec.fields.is_tx            = addr_ff[7] ^ host_role;
                     scan_out.rec.fields.xfer_type        = attr_ff[1:0];
                     scan_out.rec.fields.max_packet       = psize_ff;
                     scan_out.rec.fields.max_pkt_units    = psize_ff[10:3];
                     scan_out.rec.fields.poll_interval    =
                        (host_role && attr_ff[1:0] != XFER_BULK) ? data_byte : 8'h00;
                     scan_out.rec.fields.int_bank         = addr_ff[3];
                  end
                  default: begin
                  end
               endcase
            end
            off_in = (off_plus >= {1'b0, len_ff}) ? '0 : off_plus[7:0];
         end
      end

      max_intf_in = n_max_intf;
      max_endp_in = n_max_endp;
      bad_in      = n_bad;

      // end of set: summary, then restart the scan
      if (last_byte) begin
         scan_out.sum_valid                = 1'b1;
         scan_out.sum.kind                 = KIND_SUMMARY;
         scan_out.sum.last                 = 1'b1;
         scan_out.sum.fields.intf_count    = {1'b0, n_max_intf} + 9'd1;
         scan_out.sum.fields.endp_count    = {1'b0, n_max_endp} + 5'd1;
         scan_out.sum.fields.malformed     = n_bad;
         off_in      = '0;
         len_in      = '0;
         type_in     = '0;
         addr_in     = '0;
         attr_in     = '0;
         psize_in    = '0;
         max_intf_in = '0;
         max_endp_in = 4'd1;
         bad_in      = 1'b0;
      end
   end

   // scan state, updated on each accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff      <= '0;
         len_ff      <= '0;
         type_ff     <= '0;
         addr_ff     <= '0;
         attr_ff     <= '0;
         psize_ff    <= '0;
         max_intf_ff <= '0;
         max_endp_ff <= 4'd1;
         bad_ff      <= 1'b0;
      end else if (fire) begin
         off_ff      <= off_in;
         len_ff      <= len_in;
         type_ff     <= type_in;
         addr_ff     <= addr_in;
         attr_ff     <= attr_in;
         psize_ff    <= psize_in;
         max_intf_ff <= max_intf_in;
         max_endp_ff <= max_endp_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/usb_config_descriptor_scanner_unit.sv @@
// a result is written to the result queue when its byte is accepted and offered on the rsp side from there
// throughput: one byte per cycle; the byte at offset six of an endpoint descriptor adds a record,
// the last byte of a set adds a summary (both when they coincide), and req_tready
// drops while the four-entry result queue holds three or more results
// reset: synchronous, active high; clears scan state, queue and host_role
`default_nettype none

module usb_config_descriptor_scanner_unit
   import cdsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] endp_num, [4] is_tx, [6:5] xfer_type, [22:7] max_packet,
   // [30:23] max_pkt_units, [38:31] poll_interval, [39] int_bank,
   // [48:40] intf_count, [53:49] endp_count, [54] malformed, [55] zero
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast,   // last_result
   // host role register
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   logic              host_role_ff;
   logic              fire;
   scan_out_type      scan_out;

   result_type        queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [CntW-1:0]   push_cnt;
   logic [CntW-1:0]   pop_cnt;
   logic [PtrW-1:0]   sum_ptr;
   logic              pop;
   result_type        head;

   // host role register
   always_ff @(posedge clock) begin
      if (reset) begin
         host_role_ff <= 1'b0;
      end else if (csr_wr_en) begin
         host_role_ff <= csr_wr_data;
      end
   end

   // room for two results is needed before a byte is taken
   assign req_tready = (count_ff <= CntW'(QUEUE_DEPTH - 2));
   assign fire       = req_tvalid && req_tready;

   cdsu_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .host_role (host_role_ff),
      .scan_out  (scan_out)
   );

   // queue pointer and fill bookkeeping
   always_comb begin
      pop      = rsp_tvalid && rsp_tready;
      push_cnt = fire ? (CntW'(scan_out.rec_valid) + CntW'(scan_out.sum_valid)) : '0;
      pop_cnt  = CntW'(pop);
      count_in = count_ff + push_cnt - pop_cnt;
      wr_ptr_in = wr_ptr_ff + push_cnt[PtrW-1:0];
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      sum_ptr   = scan_out.rec_valid ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage, record ahead of summary
   always_ff @(posedge clock) begin
      if (fire && scan_out.rec_valid) begin
         queue_ff[wr_ptr_ff] <= scan_out.rec;
      end
      if (fire && scan_out.sum_valid) begin
         queue_ff[sum_ptr] <= scan_out.sum;
      end
   end

   // result transfer from the queue head
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {1'b0, head.fields};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("end of set produced no result");

   a_summary_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SUMMARY) |-> rsp_tlast)
      else $error("summary not marked last");

   a_room_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (count_ff + CntW'(2) <= CntW'(QUEUE_DEPTH)))
      else $error("input taken without room for two results");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_usb_config_descriptor_scanner_unit.sv @@
`timescale 1ns / 1ps

module tb_usb_config_descriptor_scanner_unit;
   import cdsu_pkg::*;

   // predicts scanner results from accepted bytes and checks what comes out
   class descriptor_scan_board;
      logic          host_role;
      logic [7:0]    cur_offset;
      logic [7:0]    cur_length;
      logic [7:0]    cur_type;
      logic [7:0]    ep_address;
      logic [7:0]    ep_attributes;
      logic [15:0]   ep_packet;
      logic [7:0]    top_intf;
      logic [3:0]    top_endp;
      logic          broken;
      result_type    due_results[$];
      int            errors;

      function new();
         host_role = 1'b0;
         errors    = 0;
         restart_set();
      endfunction

      function void restart_set();
         cur_offset    = 8'd0;
         cur_length    = 8'd0;
         cur_type      = 8'd0;
         ep_address    = 8'd0;
         ep_attributes = 8'd0;
         ep_packet     = 16'd0;
         top_intf      = 8'd0;
         top_endp      = 4'd1;
         broken        = 1'b0;
      endfunction

      // one accepted byte transfer: advance the walk, queue the results it causes
      function void take_byte(logic [7:0] b, logic is_last);
         result_type r;
         logic [7:0] off;
         logic [1:0] xt;
         if (!broken) begin
            if (cur_offset == 8'd0) begin
               cur_length = b;
               if (b < MIN_DESC_LEN) broken = 1'b1;
               else cur_offset = 8'd1;
            end else begin
               off = cur_offset;
               if (off == OFS_TYPE) begin
                  cur_type = b;
               end else if (cur_type == DESC_TYPE_INTF && off == OFS_NUM) begin
                  if (b > top_intf) top_intf = b;
               end else if (cur_type == DESC_TYPE_ENDP) begin
                  case (off)
                     OFS_NUM: begin
                        ep_address = b;
                        if (b[3:0] > top_endp) top_endp = b[3:0];
                     end
                     OFS_ATTR:   ep_attributes = b;
                     OFS_PKT_LO: ep_packet = {8'h00, b};
                     OFS_PKT_HI: ep_packet = {b, ep_packet[7:0]};
                     OFS_INTERVAL: begin
                        xt = ep_attributes[1:0];
                        r = '0;
                        r.kind                 = KIND_ENDP;
                        r.last                 = !is_last;
                        r.fields.endp_num      = ep_address[3:0];
                        r.fields.is_tx         = ep_address[7] ^ host_role;
                        r.fields.xfer_type     = xt;
                        r.fields.max_packet    = ep_packet;
                        r.fields.max_pkt_units = ep_packet[10:3];
                        r.fields.poll_interval = (host_role && xt != XFER_BULK) ? b : 8'd0;
                        r.fields.int_bank      = ep_address[3];
                        due_results.push_back(r);
                     end
                     default: ;
                  endcase
               end
               cur_offset = ({1'b0, off} + 9'd1 >= {1'b0, cur_length}) ? 8'd0 : off + 8'd1;
            end
         end
         // summary closes the set and the walk starts over
         if (is_last) begin
            r = '0;
            r.kind              = KIND_SUMMARY;
            r.last              = 1'b1;
            r.fields.intf_count = {1'b0, top_intf} + 9'd1;
            r.fields.endp_count = {1'b0, top_endp} + 5'd1;
            r.fields.malformed  = broken;
            due_results.push_back(r);
            restart_set();
         end
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // one result transfer against the oldest expectation
      function void check_result(logic [55:0] d, logic k, logic lst);
         result_type  want;
         fields_type  got;
         got = d[54:0];
         if (due_results.size() == 0) begin
            $error("unexpected result: tdata %h kind %0d last %0d", d, k, lst);
            errors++;
            return;
         end
         want = due_results.pop_front();
         check_field("kind", want.kind, k);
         check_field("last_result", want.last, lst);
         check_field("endp_num", want.fields.endp_num, got.endp_num);
         check_field("is_tx", want.fields.is_tx, got.is_tx);
         check_field("xfer_type", want.fields.xfer_type, got.xfer_type);
         check_field("max_packet", want.fields.max_packet, got.max_packet);
         check_field("max_pkt_units", want.fields.max_pkt_units, got.max_pkt_units);
         check_field("poll_interval", want.fields.poll_interval, got.poll_interval);
         check_field("int_bank", want.fields.int_bank, got.int_bank);
         check_field("intf_count", want.fields.intf_count, got.intf_count);
         check_field("endp_count", want.fields.endp_count, got.endp_count);
         check_field("malformed", want.fields.malformed, got.malformed);
         check_field("tdata pad", 0, d[55]);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic        csr_wr_data;

   descriptor_scan_board board = new();
   logic [7:0]  set_q[$];
   int          bytes_sent   = 0;
   int          stall_cycles = 0;
   bit          no_idle      = 1'b0;

   usb_config_descriptor_scanner_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: random back-pressure, plus long hold-offs on request
   initial begin
      int hold;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_cycles > 0) begin
            hold = stall_cycles;
            stall_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 18);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("tb_usb_config_descriptor_scanner_unit: errors");
      $finish;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (!no_idle && $urandom_range(0, 99) < 18) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      board.take_byte(b, is_last);
      bytes_sent++;
      @(negedge clock);
   endtask

   // the next set may follow at once; wait_idle drops req_tvalid
   task automatic send_set();
      for (int i = 0; i < set_q.size(); i++)
         send_byte(set_q[i], i == set_q.size() - 1);
      set_q.delete();
   endtask

   // stop offering, wait until every expected result has arrived, then return at a falling edge
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_role(input logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.host_role = v;
   endtask

   // descriptor builders
   function automatic void add_random(int n);
      repeat (n) set_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_header();
      set_q.push_back(8'd9);
      set_q.push_back(8'd2);
      add_random(7);
   endfunction

   function automatic void add_intf();
      set_q.push_back(8'd9);
      set_q.push_back(DESC_TYPE_INTF);
      if ($urandom_range(0, 9) < 8) set_q.push_back(8'($urandom_range(0, 7)));
      else set_q.push_back(8'($urandom_range(0, 255)));
      add_random(6);
   endfunction

   function automatic void add_endp();
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : 7;
      set_q.push_back(8'(len));
      set_q.push_back(DESC_TYPE_ENDP);
      add_random(len - 2);
   endfunction

   // endpoint shorter than seven bytes, no record
   function automatic void add_short_endp();
      int len;
      len = $urandom_range(2, 6);
      set_q.push_back(8'(len));
      set_q.push_back(DESC_TYPE_ENDP);
      add_random(len - 2);
   endfunction

   function automatic void add_other();
      int len;
      len = $urandom_range(2, 12);
      set_q.push_back(8'(len));
      add_random(len - 1);
   endfunction

   // mostly well-formed sets; some truncated, malformed or plain noise
   function automatic void build_random_set();
      int mode;
      int pick;
      int keep;
      set_q.delete();
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
         add_random($urandom_range(1, 12));
      end else begin
         if ($urandom_range(0, 3) != 0) add_header();
         repeat ($urandom_range(1, 5)) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) add_intf();
            else if (pick < 7) add_endp();
            else if (pick < 8) add_short_endp();
            else add_other();
         end
         if (mode < 16) begin
            set_q.push_back(8'($urandom_range(0, 1)));
            add_random($urandom_range(0, 4));
         end else if (mode < 26 && set_q.size() > 1) begin
            keep = $urandom_range(1, set_q.size() - 1);
            while (set_q.size() > keep) void'(set_q.pop_back());
         end
      end
   endfunction

   initial begin
      int phase_bytes;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      reset       = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero length byte ending the set
      set_q = '{8'h00};
      send_set();
      // length one, remaining bytes ignored until the last
      set_q = '{8'h01, 8'h05, 8'h33};
      send_set();
      // full endpoint on the last byte: record then summary, all-ones fields but a zero poll interval
      set_q = '{8'h07, DESC_TYPE_ENDP, 8'h8f, 8'h03, 8'hff, 8'hff, 8'hff};
      send_set();
      wait_idle();
      write_role(1'b1);
      // host role: bulk endpoint drops the interval, interface number 255
      set_q = '{8'h07, DESC_TYPE_ENDP, 8'h00, 8'h02, 8'h00, 8'h00, 8'h10,
                8'h04, DESC_TYPE_INTF, 8'hff, 8'h00};
      send_set();
      // short endpoint still raises the endpoint count
      set_q = '{8'h03, DESC_TYPE_ENDP, 8'h0a};
      send_set();

      // random phases, host role alternating
      for (int ph = 0; bytes_sent < 1300; ph++) begin
         wait_idle();
         write_role(ph % 2 == 0 ? 1'b0 : 1'b1);
         no_idle = (ph == 3);
         if (ph == 2) stall_cycles = 400;
         phase_bytes = 0;
         while (phase_bytes < 160 && bytes_sent < 1300) begin
            build_random_set();
            phase_bytes += set_q.size();
            send_set();
         end
      end
      no_idle = 1'b0;

      wait_idle();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.due_results.size() == 0)
         $display("tb_usb_config_descriptor_scanner_unit: clean");
      else
         $display("tb_usb_config_descriptor_scanner_unit: errors");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cdsu_pkg.sv
rtl/cdsu_parse.sv
rtl/usb_config_descriptor_scanner_unit.sv
tb/sv/tb_usb_config_descriptor_scanner_unit.sv
